FILE: rtl/core/ble_adv_record_framer_assert.svh
// Assertion macros for the BLE advertising record framer.
`ifndef BLE_ADV_RECORD_FRAMER_ASSERT_SVH
`define BLE_ADV_RECORD_FRAMER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ARF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ble_adv_record_framer: same-cycle check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define ARF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ble_adv_record_framer: next-cycle check failed");

`endif

FILE: rtl/core/ble_arf_pkg.sv
// Shared types, constants and the CRC-24 byte update for the record framer.
package ble_arf_pkg;

  localparam int MAX_ADV_DATA_DEF = 31;
  localparam int QUEUE_DEPTH_DEF  = 2;

  localparam logic [23:0] CRC_INIT = 24'h555555;
  localparam logic [23:0] CRC_POLY = 24'hDA6000;

  // One queued command from the front to the back.
  typedef struct packed {
    logic        is_start;
    logic        last;
    logic        empty;
    logic        has_target;
    logic [7:0]  hdr;
    logic [7:0]  len;
    logic [7:0]  rssi;
    logic [7:0]  data;
    logic [47:0] adv_addr;
    logic [47:0] tgt_addr;
  } arf_entry_t;

  // Fold one byte into the CRC, LSB first, reflected polynomial.
  function automatic logic [23:0] crc_byte(input logic [23:0] crc, input logic [7:0] b);
    logic [23:0] c;
    logic        fb;
    c = crc;
    for (int j = 0; j < 8; j++) begin
      fb = b[j] ^ c[0];
      c  = c >> 1;
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

endpackage

FILE: rtl/core/ble_arf_front.sv
// Front end: accepts input beats, tracks the open record, queues commands.
module ble_arf_front #(
  parameter int MAX_ADV_DATA = ble_arf_pkg::MAX_ADV_DATA_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_action,
  input  logic [2:0]              in_adv_type,
  input  logic [1:0]              in_addr_type,
  input  logic                    in_has_target,
  input  logic [47:0]             in_adv_address,
  input  logic [47:0]             in_target_address,
  input  logic signed [7:0]       in_rssi,
  input  logic [7:0]              in_data_length,
  input  logic [7:0]              in_data_byte,
  input  logic                    q_full,
  output logic                    q_push,
  output ble_arf_pkg::arf_entry_t q_entry
);

  localparam int BL_W = $clog2(MAX_ADV_DATA + 1);
  localparam logic [7:0] MAX_LEN = 8'(MAX_ADV_DATA);

  // Advertising type to PDU type code.
  localparam logic [3:0] PDU_CODE [8] = '{4'd0, 4'd1, 4'd6, 4'd2, 4'd4, 4'd0, 4'd0, 4'd0};

  logic            in_record_r, in_record_nxt;
  logic [BL_W-1:0] bytes_left_r, bytes_left_nxt;

  logic       accept;
  logic [7:0] dlen;
  logic [8:0] len_sum;
  logic       txadd;
  logic       data_ok;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  // Clamp the data length and build the PDU header and length bytes.
  assign dlen    = (in_data_length > MAX_LEN) ? MAX_LEN : in_data_length;
  assign len_sum = 9'd6 + (in_has_target ? 9'd6 : 9'd0) + {1'b0, dlen};
  assign txadd   = in_addr_type[0];
  assign data_ok = in_record_r && (bytes_left_r != '0);

  // Classify the beat: start, data in record, or drop.
  always_comb begin
    in_record_nxt  = in_record_r;
    bytes_left_nxt = bytes_left_r;
    q_push         = 1'b0;

    q_entry.is_start   = !in_action;
    q_entry.last       = (bytes_left_r == BL_W'(1));
    q_entry.empty      = (dlen == 8'd0);
    q_entry.has_target = in_has_target;
    q_entry.hdr        = {1'b0, txadd, 2'b00, PDU_CODE[in_adv_type]};
    q_entry.len        = len_sum[7:0];
    q_entry.rssi       = in_rssi;
    q_entry.data       = in_data_byte;
    q_entry.adv_addr   = in_adv_address;
    q_entry.tgt_addr   = in_target_address;

    if (accept) begin
      if (!in_action) begin
        q_push         = 1'b1;
        in_record_nxt  = (dlen != 8'd0);
        bytes_left_nxt = BL_W'(dlen);
      end else if (data_ok) begin
        q_push         = 1'b1;
        bytes_left_nxt = bytes_left_r - BL_W'(1);
        if (bytes_left_r == BL_W'(1)) begin
          in_record_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_record_r  <= 1'b0;
      bytes_left_r <= '0;
    end else begin
      in_record_r  <= in_record_nxt;
      bytes_left_r <= bytes_left_nxt;
    end
  end

endmodule

FILE: rtl/core/ble_arf_queue.sv
// Short command queue between the front and the back.
module ble_arf_queue #(
  parameter int DEPTH = ble_arf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  ble_arf_pkg::arf_entry_t push_entry,
  output logic                    full,
  input  logic                    pop,
  output logic                    not_empty,
  output ble_arf_pkg::arf_entry_t head
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  ble_arf_pkg::arf_entry_t slot_r [DEPTH];

  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = slot_r[rd_ptr_r];

  // Advance pointers with wrap and track fill.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed entry.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

FILE: rtl/core/ble_arf_back.sv
// Back end: sequences header, data and CRC bytes into the output register.
module ble_arf_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    q_valid,
  input  ble_arf_pkg::arf_entry_t q_head,
  output logic                    q_pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [7:0]              out_byte,
  output logic                    out_end_of_record
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_HDR  = 3'b010,
    ST_CRC  = 3'b100
  } state_t;

  // Byte positions within the start burst.
  localparam logic [4:0] POS_PDU_HDR = 5'd14;
  localparam logic [4:0] POS_ADV_END = 5'd21;
  localparam logic [4:0] POS_TGT_END = 5'd27;

  state_t                  state_r, state_nxt;
  ble_arf_pkg::arf_entry_t cur_r, cur_nxt;
  logic [4:0]              pos_r, pos_nxt;
  logic [1:0]              crc_cnt_r, crc_cnt_nxt;
  logic [23:0]             crc_r, crc_nxt;
  logic                    out_valid_r;
  logic [7:0]              out_byte_r;
  logic                    out_eor_r;

  logic       adv;
  logic       emit;
  logic [7:0] emit_byte;
  logic       emit_eor;
  logic [7:0] hdr_byte;
  logic       hdr_done;

  assign adv = !out_valid_r || !out_stall;

  // Select the byte for the current position of the start burst.
  always_comb begin
    case (pos_r)
      5'd1:    hdr_byte = cur_r.rssi;
      5'd2:    hdr_byte = 8'h80;
      5'd4:    hdr_byte = 8'hD6;
      5'd5:    hdr_byte = 8'hBE;
      5'd6:    hdr_byte = 8'h89;
      5'd7:    hdr_byte = 8'h8E;
      5'd8:    hdr_byte = 8'h13;
      5'd9:    hdr_byte = 8'h0C;
      5'd10:   hdr_byte = 8'hD6;
      5'd11:   hdr_byte = 8'hBE;
      5'd12:   hdr_byte = 8'h89;
      5'd13:   hdr_byte = 8'h8E;
      5'd14:   hdr_byte = cur_r.hdr;
      5'd15:   hdr_byte = cur_r.len;
      5'd16:   hdr_byte = cur_r.adv_addr[7:0];
      5'd17:   hdr_byte = cur_r.adv_addr[15:8];
      5'd18:   hdr_byte = cur_r.adv_addr[23:16];
      5'd19:   hdr_byte = cur_r.adv_addr[31:24];
      5'd20:   hdr_byte = cur_r.adv_addr[39:32];
      5'd21:   hdr_byte = cur_r.adv_addr[47:40];
      5'd22:   hdr_byte = cur_r.tgt_addr[7:0];
      5'd23:   hdr_byte = cur_r.tgt_addr[15:8];
      5'd24:   hdr_byte = cur_r.tgt_addr[23:16];
      5'd25:   hdr_byte = cur_r.tgt_addr[31:24];
      5'd26:   hdr_byte = cur_r.tgt_addr[39:32];
      5'd27:   hdr_byte = cur_r.tgt_addr[47:40];
      default: hdr_byte = 8'h00;
    endcase
  end

  assign hdr_done = ((pos_r == POS_ADV_END) && !cur_r.has_target) || (pos_r == POS_TGT_END);

  // Sequence one byte per free output slot.
  always_comb begin
    state_nxt   = state_r;
    cur_nxt     = cur_r;
    pos_nxt     = pos_r;
    crc_cnt_nxt = crc_cnt_r;
    crc_nxt     = crc_r;
    q_pop       = 1'b0;
    emit        = 1'b0;
    emit_byte   = 8'h00;
    emit_eor    = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (q_valid && adv) begin
          q_pop = 1'b1;
          emit  = 1'b1;
          if (q_head.is_start) begin
            emit_byte = 8'h00;
            crc_nxt   = ble_arf_pkg::CRC_INIT;
            cur_nxt   = q_head;
            pos_nxt   = 5'd1;
            state_nxt = ST_HDR;
          end else begin
            emit_byte = q_head.data;
            crc_nxt   = ble_arf_pkg::crc_byte(crc_r, q_head.data);
            if (q_head.last) begin
              crc_cnt_nxt = 2'd0;
              state_nxt   = ST_CRC;
            end
          end
        end
      end
      ST_HDR: begin
        if (adv) begin
          emit      = 1'b1;
          emit_byte = hdr_byte;
          pos_nxt   = pos_r + 5'd1;
          if (pos_r >= POS_PDU_HDR) begin
            crc_nxt = ble_arf_pkg::crc_byte(crc_r, hdr_byte);
          end
          if (hdr_done) begin
            crc_cnt_nxt = 2'd0;
            state_nxt   = cur_r.empty ? ST_CRC : ST_IDLE;
          end
        end
      end
      ST_CRC: begin
        if (adv) begin
          emit        = 1'b1;
          crc_cnt_nxt = crc_cnt_r + 2'd1;
          case (crc_cnt_r)
            2'd0:    emit_byte = crc_r[7:0];
            2'd1:    emit_byte = crc_r[15:8];
            default: emit_byte = crc_r[23:16];
          endcase
          if (crc_cnt_r == 2'd2) begin
            emit_eor  = 1'b1;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      crc_r       <= ble_arf_pkg::CRC_INIT;
      pos_r       <= '0;
      crc_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      crc_r     <= crc_nxt;
      pos_r     <= pos_nxt;
      crc_cnt_r <= crc_cnt_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold the burst fields and the output beat.
  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (emit) begin
      out_byte_r <= emit_byte;
      out_eor_r  <= emit_eor;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_byte          = out_byte_r;
  assign out_end_of_record = out_eor_r;

endmodule

FILE: rtl/core/ble_adv_record_framer.sv
// Top level of the BLE advertising record framer.
//
//  channel | direction | handshake           | fields
//  in_     | input     | in_valid / in_stall | action, adv_type, addr_type, has_target,
//          |           |                     | adv_address, target_address, rssi,
//          |           |                     | data_length, data_byte
//  out_    | output    | out_valid/out_stall | out_byte, out_end_of_record
//
// A data beat inside a record yields one output byte.
// A start beat yields a burst of 22 or 28 header bytes, one per cycle unless out_stall
// holds the output, set by the back-end byte sequencer; the last data byte is followed
// by three CRC bytes. Input beats are taken while the two-entry command
// queue has room, so the front keeps accepting while the back or the output waits.
// Stray data beats are accepted and dropped. Reset is synchronous, active low.
module ble_adv_record_framer #(
  parameter int MAX_ADV_DATA = ble_arf_pkg::MAX_ADV_DATA_DEF,
  parameter int QUEUE_DEPTH  = ble_arf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_action,
  input  logic [2:0]        in_adv_type,
  input  logic [1:0]        in_addr_type,
  input  logic              in_has_target,
  input  logic [47:0]       in_adv_address,
  input  logic [47:0]       in_target_address,
  input  logic signed [7:0] in_rssi,
  input  logic [7:0]        in_data_length,
  input  logic [7:0]        in_data_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_byte,
  output logic              out_end_of_record
);

  `include "ble_adv_record_framer_assert.svh"

  logic                    q_full;
  logic                    q_push;
  logic                    q_pop;
  logic                    q_valid;
  ble_arf_pkg::arf_entry_t q_entry;
  ble_arf_pkg::arf_entry_t q_head;

  ble_arf_front #(
    .MAX_ADV_DATA (MAX_ADV_DATA)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_adv_type       (in_adv_type),
    .in_addr_type      (in_addr_type),
    .in_has_target     (in_has_target),
    .in_adv_address    (in_adv_address),
    .in_target_address (in_target_address),
    .in_rssi           (in_rssi),
    .in_data_length    (in_data_length),
    .in_data_byte      (in_data_byte),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_entry           (q_entry)
  );

  ble_arf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .not_empty  (q_valid),
    .head       (q_head)
  );

  ble_arf_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_head            (q_head),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_byte          (out_byte),
    .out_end_of_record (out_end_of_record)
  );

  // Queue integrity between front and back.
  `ARF_ASSERT_NOW(a_no_push_when_full, q_push, !q_full)
  `ARF_ASSERT_NOW(a_no_pop_when_empty, q_pop, q_valid)
  `ARF_ASSERT_NEXT(a_full_needs_push, !q_full && !q_push, !q_full)

endmodule

FILE: tb/tb_ble_adv_record_framer.sv
// Self-checking testbench for the BLE advertising record framer.
module tb_ble_adv_record_framer;

  typedef enum logic {
    ACT_START = 1'b0,
    ACT_DATA  = 1'b1
  } arf_action_e;

  typedef struct packed {
    arf_action_e       action;
    logic [2:0]        adv_type;
    logic [1:0]        addr_type;
    logic              has_target;
    logic [47:0]       adv_address;
    logic [47:0]       target_address;
    logic signed [7:0] rssi;
    logic [7:0]        data_length;
    logic [7:0]        data_byte;
  } adv_item_t;

  localparam int          ADV_DATA_MAX = ble_arf_pkg::MAX_ADV_DATA_DEF;
  localparam logic [31:0] ACCESS_WORD  = 32'h8E89BED6;
  localparam logic [15:0] CAPTURE_FLAGS = 16'h0C13;
  localparam int          DRAIN_CYCLES = 40;
  localparam int          ITEMS_PER_PHASE = 26;

  // Framed-byte predictor and the queue of bytes still owed by the block
  class framed_record_tracker;
    bit          open_record;
    int unsigned data_left;
    logic [23:0] crc_acc;
    logic [8:0]  owed_bytes[$];  // {end_of_record, byte}
    int          mismatches;

    function new();
      open_record = 1'b0;
      data_left   = 0;
      crc_acc     = ble_arf_pkg::CRC_INIT;
      mismatches  = 0;
    endfunction

    function void owe(logic [7:0] b, logic eor, bit in_crc);
      logic fb;
      if (in_crc) begin
        for (int j = 0; j < 8; j++) begin
          fb      = b[j] ^ crc_acc[0];
          crc_acc = {1'b0, crc_acc[23:1]} ^ (fb ? ble_arf_pkg::CRC_POLY : 24'h0);
        end
      end
      owed_bytes.insert(owed_bytes.size(), {eor, b});
    endfunction

    function void owe_crc_tail();
      owe(crc_acc[7:0], 1'b0, 1'b0);
      owe(crc_acc[15:8], 1'b0, 1'b0);
      owe(crc_acc[23:16], 1'b1, 1'b0);
      open_record = 1'b0;
      data_left   = 0;
    endfunction

    function logic [3:0] pdu_code(logic [2:0] adv_type);
      case (adv_type)
        3'd1:    return 4'd1;
        3'd2:    return 4'd6;
        3'd3:    return 4'd2;
        3'd4:    return 4'd4;
        default: return 4'd0;
      endcase
    endfunction

    // Work out every byte one accepted input beat causes
    function void note_beat(adv_item_t it);
      int unsigned dlen;
      logic [7:0]  hdr;
      if (it.action == ACT_START) begin
        dlen    = (it.data_length > ADV_DATA_MAX) ? ADV_DATA_MAX : it.data_length;
        crc_acc = ble_arf_pkg::CRC_INIT;
        owe(8'h00, 1'b0, 1'b0);
        owe(it.rssi, 1'b0, 1'b0);
        owe(8'h80, 1'b0, 1'b0);
        owe(8'h00, 1'b0, 1'b0);
        for (int i = 0; i < 4; i++) owe(ACCESS_WORD[8*i +: 8], 1'b0, 1'b0);
        owe(CAPTURE_FLAGS[7:0], 1'b0, 1'b0);
        owe(CAPTURE_FLAGS[15:8], 1'b0, 1'b0);
        for (int i = 0; i < 4; i++) owe(ACCESS_WORD[8*i +: 8], 1'b0, 1'b0);
        hdr = {4'h0, pdu_code(it.adv_type)};
        if (it.addr_type == 2'd1 || it.addr_type == 2'd3) hdr[6] = 1'b1;
        owe(hdr, 1'b0, 1'b1);
        owe(8'(6 + (it.has_target ? 6 : 0) + dlen), 1'b0, 1'b1);
        for (int i = 0; i < 6; i++) owe(it.adv_address[8*i +: 8], 1'b0, 1'b1);
        if (it.has_target)
          for (int i = 0; i < 6; i++) owe(it.target_address[8*i +: 8], 1'b0, 1'b1);
        if (dlen == 0) begin
          owe_crc_tail();
        end else begin
          open_record = 1'b1;
          data_left   = dlen;
        end
      end else if (open_record && data_left != 0) begin
        owe(it.data_byte, 1'b0, 1'b1);
        data_left--;
        if (data_left == 0) owe_crc_tail();
      end
    endfunction

    // Compare one accepted output beat with the oldest owed byte
    function void check_byte(logic [7:0] b, logic eor);
      logic [8:0] exp_beat;
      if (owed_bytes.size() == 0) begin
        $display("%0t: unexpected byte %02h end_of_record %0b, nothing pending",
                 $time, b, eor);
        mismatches++;
        return;
      end
      exp_beat = owed_bytes.pop_front();
      if (b !== exp_beat[7:0]) begin
        $display("%0t: out_byte expected %02h actual %02h", $time, exp_beat[7:0], b);
        mismatches++;
      end
      if (eor !== exp_beat[8]) begin
        $display("%0t: out_end_of_record expected %0b actual %0b", $time, exp_beat[8], eor);
        mismatches++;
      end
    endfunction

    function int pending();
      return owed_bytes.size();
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic              in_action;
  logic [2:0]        in_adv_type;
  logic [1:0]        in_addr_type;
  logic              in_has_target;
  logic [47:0]       in_adv_address;
  logic [47:0]       in_target_address;
  logic signed [7:0] in_rssi;
  logic [7:0]        in_data_length;
  logic [7:0]        in_data_byte;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [7:0]        out_byte;
  logic              out_end_of_record;

  framed_record_tracker tracker = new();
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int items_sent     = 0;

  ble_adv_record_framer i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_adv_type       (in_adv_type),
    .in_addr_type      (in_addr_type),
    .in_has_target     (in_has_target),
    .in_adv_address    (in_adv_address),
    .in_target_address (in_target_address),
    .in_rssi           (in_rssi),
    .in_data_length    (in_data_length),
    .in_data_byte      (in_data_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_byte          (out_byte),
    .out_end_of_record (out_end_of_record)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stall the result channel at random
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Note accepted input beats first, then check accepted output beats
  always @(posedge clk) begin
    adv_item_t seen;
    if (rst_n && in_valid && !in_stall) begin
      seen.action         = arf_action_e'(in_action);
      seen.adv_type       = in_adv_type;
      seen.addr_type      = in_addr_type;
      seen.has_target     = in_has_target;
      seen.adv_address    = in_adv_address;
      seen.target_address = in_target_address;
      seen.rssi           = in_rssi;
      seen.data_length    = in_data_length;
      seen.data_byte      = in_data_byte;
      tracker.note_beat(seen);
    end
    if (rst_n && out_valid && !out_stall)
      tracker.check_byte(out_byte, out_end_of_record);
  end

  function automatic adv_item_t random_item(arf_action_e act);
    adv_item_t it;
    it.action         = act;
    it.adv_type       = 3'($urandom);
    it.addr_type      = 2'($urandom);
    it.has_target     = 1'($urandom);
    it.adv_address    = 48'({$urandom, $urandom});
    it.target_address = 48'({$urandom, $urandom});
    it.rssi           = 8'($urandom);
    it.data_length    = 8'($urandom);
    it.data_byte      = 8'($urandom);
    return it;
  endfunction

  function automatic adv_item_t start_item(logic [2:0] adv, logic [1:0] addr, logic tgt,
                                           logic [47:0] adva, logic [7:0] rssi,
                                           logic [7:0] dlen);
    adv_item_t it;
    it             = random_item(ACT_START);
    it.adv_type    = adv;
    it.addr_type   = addr;
    it.has_target  = tgt;
    it.adv_address = adva;
    it.rssi        = rssi;
    it.data_length = dlen;
    return it;
  endfunction

  function automatic adv_item_t data_item(logic [7:0] b);
    adv_item_t it;
    it           = random_item(ACT_DATA);
    it.data_byte = b;
    return it;
  endfunction

  // Drive one beat at the falling edge and hold it until accepted
  task automatic send_beat(adv_item_t it);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_action         <= it.action;
    in_adv_type       <= it.adv_type;
    in_addr_type      <= it.addr_type;
    in_has_target     <= it.has_target;
    in_adv_address    <= it.adv_address;
    in_target_address <= it.target_address;
    in_rssi           <= it.rssi;
    in_data_length    <= it.data_length;
    in_data_byte      <= it.data_byte;
    in_valid          <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  // Send one record with random content, sometimes cut short or trailed by a stray beat
  task automatic send_record();
    adv_item_t   it;
    int          pick;
    int unsigned eff_len;
    int unsigned n_data;
    it   = random_item(ACT_START);
    pick = $urandom_range(99);
    if (pick < 10) it.data_length = 8'd0;
    else if (pick < 75) it.data_length = 8'($urandom_range(1, 6));
    else if (pick < 90) it.data_length = 8'($urandom_range(7, ADV_DATA_MAX));
    else it.data_length = 8'($urandom_range(ADV_DATA_MAX + 1, 255));
    eff_len = (it.data_length > ADV_DATA_MAX) ? ADV_DATA_MAX : it.data_length;
    n_data  = eff_len;
    if (eff_len > 1 && $urandom_range(99) < 10) n_data = $urandom_range(0, eff_len - 1);
    send_beat(it);
    for (int i = 0; i < n_data; i++) send_beat(random_item(ACT_DATA));
    items_sent += 1 + n_data;
    if ($urandom_range(99) < 12) begin
      send_beat(random_item(ACT_DATA));
      items_sent += 1;
    end
  endtask

  initial begin
    adv_item_t directed[$];
    int        phase_idle[4];
    int        phase_stall[4];
    int        phase_goal;

    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_action         = ACT_START;
    in_adv_type       = '0;
    in_addr_type      = '0;
    in_has_target     = 1'b0;
    in_adv_address    = '0;
    in_target_address = '0;
    in_rssi           = '0;
    in_data_length    = '0;
    in_data_byte      = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: stray data, empty record, field extremes, every type, restart, clamp
    directed = {directed, data_item(8'hFF)};
    directed = {directed, start_item(3'd0, 2'd0, 1'b0, 48'h0, 8'h80, 8'd0)};
    directed = {directed, start_item(3'd1, 2'd1, 1'b1, '1, 8'h7F, 8'd2)};
    directed[$].target_address = '1;
    directed = {directed, data_item(8'h00)};
    directed = {directed, data_item(8'hFF)};
    directed = {directed, data_item(8'h55)};
    directed = {directed, start_item(3'd2, 2'd2, 1'b0, 48'hA5A5_5A5A_0F0F, 8'h00, 8'd3)};
    directed = {directed, data_item(8'hA5)};
    directed = {directed, start_item(3'd3, 2'd3, 1'b1, 48'h0123_4567_89AB, 8'hC4, 8'd255)};
    directed[$].target_address = 48'h0;
    directed = {directed, data_item(8'h5A)};
    directed = {directed, data_item(8'h3C)};
    directed = {directed, start_item(3'd4, 2'd0, 1'b0, '1, 8'hFF, 8'd1)};
    directed = {directed, data_item(8'h81)};
    directed = {directed, start_item(3'd5, 2'd1, 1'b0, 48'h0, 8'h01, 8'd0)};
    directed = {directed, start_item(3'd6, 2'd2, 1'b1, 48'h8000_0000_0001, 8'h80, 8'd0)};
    directed = {directed, start_item(3'd7, 2'd3, 1'b0, 48'h7FFF_FFFF_FFFE, 8'h7F, 8'd0)};
    directed = {directed, data_item(8'h42)};
    directed = {directed, start_item(3'd2, 2'd0, 1'b0, 48'h1122_3344_5566, 8'hE0, 8'd32)};
    foreach (directed[i]) send_beat(directed[i]);

    // Random records across idle and stall mixes
    phase_idle  = '{0, 47, 0, 17};
    phase_stall = '{0, 0, 47, 17};
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = phase_idle[p];
      recv_stall_pct = phase_stall[p];
      // Hold off the sender once until the block has drained
      if (p == 2) begin
        @(negedge clk);
        in_valid <= 1'b0;
        while (tracker.pending() != 0) @(negedge clk);
      end
      phase_goal = items_sent + ITEMS_PER_PHASE;
      while (items_sent < phase_goal) send_record();
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (tracker.pending() != 0)
      $display("%0t: %0d expected bytes never arrived", $time, tracker.pending());
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: end the run if the block hangs
  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
